[hdl/dst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the depth and stencil fragment test.
// Used by dst_ctrl, dst_datapath and depth_stencil_fragment_test.

package dst_pkg;

    // Default geometry and store widths.
    localparam int FB_WIDTH_DEF     = 1024;
    localparam int FB_HEIGHT_DEF    = 1024;
    localparam int DEPTH_BITS_DEF   = 24;
    localparam int STENCIL_BITS_DEF = 8;

    // Fixed field widths of the fragment and result transfers.
    localparam int COORD_W   = 10;
    localparam int FDEPTH_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int SOP_W     = 3;
    localparam int SREF_W    = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STENCIL_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STENCIL_OP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STENCIL_REF    = 2'd3;

    // Stencil operation codes; codes above the last one act like none.
    localparam logic [SOP_W-1:0] SOP_NONE       = 3'd0;
    localparam logic [SOP_W-1:0] SOP_EQUAL      = 3'd1;
    localparam logic [SOP_W-1:0] SOP_LESS       = 3'd2;
    localparam logic [SOP_W-1:0] SOP_LESS_WR    = 3'd3;
    localparam logic [SOP_W-1:0] SOP_GREATER    = 3'd4;
    localparam logic [SOP_W-1:0] SOP_GREATER_WR = 3'd5;

    // Fragment transfer payload.
    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [FDEPTH_W-1:0] frag_depth;
    } t_frag;

    // Result transfer payload.
    typedef struct packed {
        logic               keep;
        logic               depth_pass;
        logic               stencil_hit;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic eval;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

[hdl/dst_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine for the depth and stencil fragment test.
// Depends on dst_pkg for the command and status structs.

module dst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dst_pkg::t_sts i_sts,
    output dst_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EVAL  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.out_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // At most one command is issued in a cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr_step, o_cmd.load, o_cmd.eval}))
        else $error("more than one datapath command in a cycle");

    // A loaded fragment is always followed by its evaluation state.
    a_load_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EVAL))
        else $error("load not followed by evaluation");

    // No fragment is taken while the stores are being cleared.
    a_no_load_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("fragment accepted during clearing pass");

endmodule

[hdl/dst_datapath.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, depth and stencil stores, tests and
// the result register. Depends on dst_pkg for payload and command types.

module dst_datapath #(
    parameter int FB_WIDTH     = dst_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT    = dst_pkg::FB_HEIGHT_DEF,
    parameter int DEPTH_BITS   = dst_pkg::DEPTH_BITS_DEF,
    parameter int STENCIL_BITS = dst_pkg::STENCIL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dst_pkg::t_frag                    i_in_data,
    input  logic                              i_cfg_valid,
    input  logic [dst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dst_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dst_pkg::t_result                  o_out_data,
    input  dst_pkg::t_cmd                     i_cmd,
    output dst_pkg::t_sts                     o_sts
);

    localparam int PIX_COUNT = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W    = $clog2(PIX_COUNT);

    // Configuration registers.
    logic                      r_depth_mode;
    logic                      r_stencil_enable;
    logic [dst_pkg::SOP_W-1:0] r_stencil_op;
    logic [dst_pkg::SREF_W-1:0] r_stencil_ref;

    // Stores.
    logic [DEPTH_BITS-1:0]   r_depth_mem   [PIX_COUNT];
    logic [STENCIL_BITS-1:0] r_stencil_mem [PIX_COUNT];
    logic [DEPTH_BITS-1:0]   r_depth_rd;
    logic [STENCIL_BITS-1:0] r_stencil_rd;

    // Clearing pass address.
    logic [ADDR_W-1:0] r_clr_addr;

    // Captured fragment.
    logic [dst_pkg::COORD_W-1:0] r_x;
    logic [dst_pkg::COORD_W-1:0] r_y;
    logic [DEPTH_BITS-1:0]       r_d;
    logic [ADDR_W-1:0]           r_idx;
    logic                        r_in_range;

    // Result register.
    logic             r_out_valid;
    dst_pkg::t_result r_out;

    logic [31:0]             w_idx_full;
    logic                    w_in_range;
    logic                    w_dpass;
    logic                    w_hit;
    logic                    w_shit;
    logic                    w_swrite;
    logic [STENCIL_BITS-1:0] w_ref;

    // Configuration writes; the port never holds off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode     <= 1'b0;
            r_stencil_enable <= 1'b0;
            r_stencil_op     <= '0;
            r_stencil_ref    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dst_pkg::CFG_DEPTH_MODE:     r_depth_mode     <= i_cfg_data[0];
                dst_pkg::CFG_STENCIL_ENABLE: r_stencil_enable <= i_cfg_data[0];
                dst_pkg::CFG_STENCIL_OP:
                    r_stencil_op <= i_cfg_data[dst_pkg::SOP_W-1:0];
                dst_pkg::CFG_STENCIL_REF:
                    r_stencil_ref <= i_cfg_data[dst_pkg::SREF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Store index of the incoming fragment and its range check.
    assign w_idx_full = 32'(i_in_data.pixel_y) * 32'(FB_WIDTH) + 32'(i_in_data.pixel_x);
    assign w_in_range = (32'(i_in_data.pixel_x) < 32'(FB_WIDTH)) &&
                        (32'(i_in_data.pixel_y) < 32'(FB_HEIGHT));

    // Capture the fragment when it is transferred in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x        <= i_in_data.pixel_x;
            r_y        <= i_in_data.pixel_y;
            r_d        <= DEPTH_BITS'(i_in_data.frag_depth);
            r_idx      <= w_idx_full[ADDR_W-1:0];
            r_in_range <= w_in_range;
        end
    end

    // Store reads, issued in the transfer cycle and registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_depth_rd   <= r_depth_mem[w_idx_full[ADDR_W-1:0]];
            r_stencil_rd <= r_stencil_mem[w_idx_full[ADDR_W-1:0]];
        end
    end

    // Depth test, then the stencil test on a passing fragment.
    assign w_ref   = STENCIL_BITS'(r_stencil_ref);
    assign w_dpass = r_in_range &&
                     (r_depth_mode ? (r_d <= r_depth_rd) : (r_d >= r_depth_rd));

    always_comb begin
        unique case (r_stencil_op) inside
            dst_pkg::SOP_EQUAL:                            w_hit = (r_stencil_rd == w_ref);
            dst_pkg::SOP_LESS, dst_pkg::SOP_LESS_WR:       w_hit = (r_stencil_rd < w_ref);
            dst_pkg::SOP_GREATER, dst_pkg::SOP_GREATER_WR: w_hit = (r_stencil_rd > w_ref);
            default:                                       w_hit = 1'b1;
        endcase
    end

    assign w_shit   = w_dpass && r_stencil_enable && w_hit;
    assign w_swrite = w_shit && ((r_stencil_op == dst_pkg::SOP_LESS_WR) ||
                                 (r_stencil_op == dst_pkg::SOP_GREATER_WR));

    // Store writes: the clearing pass after reset, or the evaluated fragment.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_depth_mem[r_clr_addr]   <= '0;
            r_stencil_mem[r_clr_addr] <= '0;
        end else if (i_cmd.eval) begin
            if (w_dpass) begin
                r_depth_mem[r_idx] <= r_d;
            end
            if (w_swrite) begin
                r_stencil_mem[r_idx] <= w_ref;
            end
        end
    end

    // Clearing pass address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == ADDR_W'(PIX_COUNT - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Result register; it holds while the far side stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.eval) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_out.keep        <= w_dpass && !w_shit;
            r_out.depth_pass  <= w_dpass;
            r_out.stencil_hit <= w_shit;
            r_out.out_x       <= r_x;
            r_out.out_y       <= r_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An evaluation always leaves a result waiting.
    a_eval_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |=> r_out_valid)
        else $error("evaluation produced no result");

    // Evaluation only happens when the result register can take it.
    a_eval_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> o_sts.out_free)
        else $error("result overwritten before transfer");

    // A kept fragment passed depth and was not dropped by stencil.
    a_keep_cons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.keep |-> r_out.depth_pass && !r_out.stencil_hit)
        else $error("inconsistent result flags");

endmodule

[hdl/depth_stencil_fragment_test.sv]
`timescale 1ns / 1ps
// Each fragment's store read is registered; it is evaluated once the result
// register is free, and the result is registered. A new fragment is taken only
// after the last is evaluated, set by the registered store read followed by the
// read-modify-write of the same single-port stores. Reset: synchronous, active
// low. After reset a clearing pass writes zero to all FB_WIDTH*FB_HEIGHT store
// entries with the fragment input stalled; configuration writes are taken throughout.

module depth_stencil_fragment_test #(
    parameter int FB_WIDTH     = dst_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT    = dst_pkg::FB_HEIGHT_DEF,
    parameter int DEPTH_BITS   = dst_pkg::DEPTH_BITS_DEF,
    parameter int STENCIL_BITS = dst_pkg::STENCIL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dst_pkg::t_frag                i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dst_pkg::t_result              o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dst_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    dst_pkg::t_cmd w_cmd;
    dst_pkg::t_sts w_sts;

    // Configuration registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencing of clearing pass, fragment transfer and evaluation.
    dst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Stores, tests and result register.
    dst_datapath #(
        .FB_WIDTH     (FB_WIDTH),
        .FB_HEIGHT    (FB_HEIGHT),
        .DEPTH_BITS   (DEPTH_BITS),
        .STENCIL_BITS (STENCIL_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

[verif/tb_depth_stencil_fragment_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for depth_stencil_fragment_test: directed and random fragments,
// predicted per pixel against mirrored depth and stencil stores. Depends on dst_pkg and the RTL.

module tb_depth_stencil_fragment_test;

    // Clock, reset and block ports; every input starts at a known value.
    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    dst_pkg::t_frag                i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    dst_pkg::t_result              o_out_data;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [dst_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [dst_pkg::CFG_DAT_W-1:0] i_cfg_data  = '0;

    // Mirrored register settings, updated when a register write transfers.
    logic                       cfg_ortho      = 1'b0;
    logic                       cfg_stencil_on = 1'b0;
    logic [dst_pkg::SOP_W-1:0]  cfg_sop        = dst_pkg::SOP_NONE;
    logic [dst_pkg::SREF_W-1:0] cfg_sref       = '0;

    // Mirrored per-pixel stores, indexed by {y, x}; both start cleared.
    bit [dst_pkg::FDEPTH_W-1:0] depth_mem   [0:(1 << (2 * dst_pkg::COORD_W)) - 1];
    bit [dst_pkg::SREF_W-1:0]   stencil_mem [0:(1 << (2 * dst_pkg::COORD_W)) - 1];

    // Predicted fragment outcomes waiting for their result transfer.
    dst_pkg::t_result awaited_outcomes[$];

    // When set, neither side inserts gaps or stalls.
    bit gaps_off = 1'b0;

    int mismatch_count = 0;
    int frags_sent     = 0;
    int results_seen   = 0;
    int kept_count     = 0;
    int depth_passes   = 0;
    int stencil_drops  = 0;
    int settings_used  = 0;
    int stall_left     = 0;

    depth_stencil_fragment_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int unsigned roll;
        if (gaps_off) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Applies the depth and stencil tests to one fragment and updates the mirrored stores.
    function automatic dst_pkg::t_result predict_fragment(dst_pkg::t_frag f);
        dst_pkg::t_result              r;
        logic [2*dst_pkg::COORD_W-1:0] pix;
        logic [dst_pkg::FDEPTH_W-1:0]  stored;
        logic                          hit;
        r       = '0;
        r.out_x = f.pixel_x;
        r.out_y = f.pixel_y;
        pix     = {f.pixel_y, f.pixel_x};
        stored  = depth_mem[pix];
        // The default framebuffer covers every coordinate the fields can carry.
        if (cfg_ortho ? (f.frag_depth <= stored) : (f.frag_depth >= stored)) begin
            depth_mem[pix] = f.frag_depth;
            r.depth_pass   = 1'b1;
            if (cfg_stencil_on) begin
                case (cfg_sop)
                    dst_pkg::SOP_EQUAL:
                        hit = (stencil_mem[pix] == cfg_sref);
                    dst_pkg::SOP_LESS, dst_pkg::SOP_LESS_WR:
                        hit = (stencil_mem[pix] < cfg_sref);
                    dst_pkg::SOP_GREATER, dst_pkg::SOP_GREATER_WR:
                        hit = (stencil_mem[pix] > cfg_sref);
                    // None and the unused codes always drop without writing.
                    default:
                        hit = 1'b1;
                endcase
                if (hit && (cfg_sop == dst_pkg::SOP_LESS_WR ||
                            cfg_sop == dst_pkg::SOP_GREATER_WR)) begin
                    stencil_mem[pix] = cfg_sref;
                end
                r.stencil_hit = hit;
            end
            r.keep = !r.stencil_hit;
        end
        return r;
    endfunction

    function automatic dst_pkg::t_frag mk_frag(input int x, input int y, input int d);
        dst_pkg::t_frag f;
        f.pixel_x    = dst_pkg::COORD_W'(x);
        f.pixel_y    = dst_pkg::COORD_W'(y);
        f.frag_depth = dst_pkg::FDEPTH_W'(d);
        return f;
    endfunction

    // Random fragment: mostly a few hot pixels so tests hit stored values, depths near them.
    function automatic dst_pkg::t_frag random_frag();
        dst_pkg::t_frag f;
        int unsigned    roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            f.pixel_x = dst_pkg::COORD_W'($urandom_range(0, 3));
            f.pixel_y = dst_pkg::COORD_W'($urandom_range(0, 3));
        end else if (roll < 65) begin
            f.pixel_x = dst_pkg::COORD_W'($urandom_range(1020, 1023));
            f.pixel_y = dst_pkg::COORD_W'($urandom_range(1020, 1023));
        end else begin
            f.pixel_x = dst_pkg::COORD_W'($urandom);
            f.pixel_y = dst_pkg::COORD_W'($urandom);
        end
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            f.frag_depth = depth_mem[{f.pixel_y, f.pixel_x}]
                           + dst_pkg::FDEPTH_W'($urandom_range(0, 4))
                           - dst_pkg::FDEPTH_W'(2);
        end else if (roll < 45) begin
            f.frag_depth = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            f.frag_depth = dst_pkg::FDEPTH_W'($urandom);
        end
        return f;
    endfunction

    // Sends one fragment after a random gap and records its predicted outcome on transfer.
    // Valid is left high so a back-to-back fragment needs no second assignment.
    task automatic send_frag(input dst_pkg::t_frag f);
        int               gap;
        dst_pkg::t_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            if (i_in_valid) i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(posedge i_clk); while (o_in_stall);
        predicted        = predict_fragment(f);
        awaited_outcomes = {awaited_outcomes, predicted};
        frags_sent++;
    endtask

    // Stops sending and waits until every predicted outcome has been checked.
    task automatic drain();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // One register write; valid stays high for the next write in the same burst.
    task automatic write_reg(input logic [dst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dst_pkg::CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            dst_pkg::CFG_DEPTH_MODE:     cfg_ortho      = data[0];
            dst_pkg::CFG_STENCIL_ENABLE: cfg_stencil_on = data[0];
            dst_pkg::CFG_STENCIL_OP:     cfg_sop        = data[dst_pkg::SOP_W-1:0];
            dst_pkg::CFG_STENCIL_REF:    cfg_sref       = data[dst_pkg::SREF_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all four registers with raw bytes; bits above each field must be ignored.
    task automatic program_regs(input logic [7:0] mode_raw, input logic [7:0] en_raw,
                                input logic [7:0] op_raw, input logic [7:0] ref_raw);
        write_reg(dst_pkg::CFG_DEPTH_MODE, mode_raw);
        write_reg(dst_pkg::CFG_STENCIL_ENABLE, en_raw);
        write_reg(dst_pkg::CFG_STENCIL_OP, op_raw);
        write_reg(dst_pkg::CFG_STENCIL_REF, ref_raw);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Compares one result transfer with the oldest predicted outcome.
    task automatic check_result(input dst_pkg::t_result got);
        dst_pkg::t_result want;
        results_seen++;
        if (awaited_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("Unexpected result at %0t: keep=%0b dpass=%0b shit=%0b x=%0d y=%0d",
                         $realtime, got.keep, got.depth_pass, got.stencil_hit,
                         got.out_x, got.out_y);
            end
            return;
        end
        want = awaited_outcomes.pop_front();
        if (got.keep !== want.keep || got.depth_pass !== want.depth_pass ||
            got.stencil_hit !== want.stencil_hit || got.out_x !== want.out_x ||
            got.out_y !== want.out_y) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("Mismatch at %0t: expected keep=%0b dpass=%0b shit=%0b x=%0d y=%0d",
                         $realtime, want.keep, want.depth_pass, want.stencil_hit,
                         want.out_x, want.out_y);
                $display("                 actual keep=%0b dpass=%0b shit=%0b x=%0d y=%0d",
                         got.keep, got.depth_pass, got.stencil_hit, got.out_x, got.out_y);
            end
        end else begin
            kept_count    += want.keep;
            depth_passes  += want.depth_pass;
            stencil_drops += want.stencil_hit;
        end
    endtask

    // Result side: check each transfer, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= stall_left - 1;
            end else if (!gaps_off && $urandom_range(0, 99) < 20) begin
                i_out_stall <= 1'b1;
                stall_left  <= pick_gap();
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Depth compare at the code extremes in both modes, with stray high register bits.
    task automatic test_depth_extremes();
        program_regs(8'hFE, 8'h02, 8'hF8, 8'h00);
        send_frag(mk_frag(0, 0, 0));
        send_frag(mk_frag(1023, 1023, 24'hFFFFFF));
        send_frag(mk_frag(1023, 1023, 0));
        send_frag(mk_frag(1023, 0, 1));
        send_frag(mk_frag(0, 1023, 24'hFFFFFF));
        drain();
        program_regs(8'h01, 8'h00, 8'h00, 8'hFF);
        send_frag(mk_frag(1023, 1023, 24'hFFFFFF));
        send_frag(mk_frag(1023, 1023, 24'hFFFFFE));
        send_frag(mk_frag(1023, 1023, 24'hFFFFFF));
        send_frag(mk_frag(0, 0, 0));
        send_frag(mk_frag(2, 2, 1));
        drain();
    endtask

    // Runs one passing-depth fragment on a single pixel under the given stencil setting.
    task automatic stencil_case(input logic [7:0] op_raw, input logic [7:0] ref_raw);
        program_regs(8'h00, 8'h01, op_raw, ref_raw);
        send_frag(mk_frag(4, 4, 24'hFFFFFF));
        drain();
    endtask

    // Every stencil operation, both reference extremes, the unused codes,
    // and a failing depth with stenciling on.
    task automatic test_stencil_ops();
        stencil_case({5'd0, dst_pkg::SOP_NONE}, 8'h00);
        stencil_case({5'd0, dst_pkg::SOP_EQUAL}, 8'h00);
        stencil_case({5'd0, dst_pkg::SOP_LESS}, 8'hFF);
        stencil_case({5'd0, dst_pkg::SOP_LESS_WR}, 8'hFF);
        stencil_case({5'd0, dst_pkg::SOP_EQUAL}, 8'hFF);
        stencil_case({5'd0, dst_pkg::SOP_GREATER}, 8'hFF);
        stencil_case({5'd0, dst_pkg::SOP_GREATER_WR}, 8'h00);
        stencil_case({5'd0, dst_pkg::SOP_LESS}, 8'h00);
        stencil_case(8'h06, 8'h00);
        program_regs(8'h00, 8'hFF, 8'hFF, 8'h80);
        send_frag(mk_frag(4, 4, 24'hFFFFFF));
        send_frag(mk_frag(4, 4, 0));
        drain();
    endtask

    // Random settings per phase, the extremes first; some phases run without gaps.
    task automatic test_random_traffic();
        logic [7:0] mode_raw, en_raw, op_raw, ref_raw;
        for (int phase = 0; phase < 11; phase++) begin
            mode_raw = 8'($urandom);
            en_raw   = 8'($urandom);
            op_raw   = 8'($urandom);
            ref_raw  = 8'($urandom);
            if (phase == 0) begin
                mode_raw[0] = 1'b0;
                en_raw[0]   = 1'b1;
                op_raw[2:0] = dst_pkg::SOP_GREATER_WR;
                ref_raw     = 8'hFF;
            end else if (phase == 1) begin
                mode_raw[0] = 1'b1;
                en_raw[0]   = 1'b1;
                op_raw[2:0] = dst_pkg::SOP_LESS_WR;
                ref_raw     = 8'h00;
            end else if ($urandom_range(0, 9) < 7) begin
                en_raw[0] = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) ref_raw = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            program_regs(mode_raw, en_raw, op_raw, ref_raw);
            gaps_off = (phase % 4 == 3);
            repeat (148) send_frag(random_frag());
            drain();
        end
        gaps_off = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_depth_extremes();
        test_stencil_ops();
        test_random_traffic();
        drain();
        repeat (10) @(posedge i_clk);
        if (awaited_outcomes.size() != 0) begin
            mismatch_count += awaited_outcomes.size();
            $display("%0d predicted results never arrived", awaited_outcomes.size());
        end
        $display("Sent %0d fragments under %0d register settings; %0d results checked.",
                 frags_sent, settings_used, results_seen);
        $display("Outcomes: %0d kept, %0d depth passes, %0d stencil drops, %0d mismatches.",
                 kept_count, depth_passes, stencil_drops, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** depth_stencil_fragment_test: PASSED **");
        end else begin
            $display("** depth_stencil_fragment_test: FAILED **");
        end
        $finish;
    end

    // Watchdog: the run includes the clearing pass over every store entry after reset.
    initial begin
        #25_000_000;
        $display("Timeout: run did not finish");
        $display("** depth_stencil_fragment_test: FAILED **");
        $finish;
    end

endmodule
